/* hdl/data_eeprom_controller_core_macros.svh */
// Assertion macros used by the checker file dee_checker.
// Expects clk and rst_n in the scope of use.
`ifndef DATA_EEPROM_CONTROLLER_CORE_MACROS_SVH
`define DATA_EEPROM_CONTROLLER_CORE_MACROS_SVH

// Checked only out of reset.
`define DEE_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DEE_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dee_pkg.sv */
// Data EEPROM controller package: codes, sizes and shared types.
// No dependencies.
package dee_pkg;

  localparam int ADDR_BITS = 8;
  localparam int MEM_AW    = (ADDR_BITS < 8) ? ADDR_BITS : 8;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam logic [1:0] FUNC_RD   = 2'd0;
  localparam logic [1:0] FUNC_WR   = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] SEL_ADDR   = 3'd0;
  localparam logic [2:0] SEL_DATA   = 3'd1;
  localparam logic [2:0] SEL_CTRL   = 3'd2;
  localparam logic [2:0] SEL_UNLOCK = 3'd3;
  localparam logic [2:0] SEL_DONE   = 3'd4;

  localparam logic [7:0] UNLOCK_FIRST  = 8'h55;
  localparam logic [7:0] UNLOCK_SECOND = 8'hAA;

  localparam logic [1:0] LOCK_IDLE = 2'd0;
  localparam logic [1:0] LOCK_HALF = 2'd1;
  localparam logic [1:0] LOCK_OPEN = 2'd2;

  localparam logic [15:0] WRITE_TICKS_RST = 16'd1000;
  localparam logic [7:0]  ERASED_BYTE     = 8'hFF;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       write_busy;
    logic       done_flag;
  } result_t;

endpackage

/* hdl/dee_if.sv */
// Valid/ready channel interfaces for request and result beats.
// No dependencies.
interface dee_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] reg_sel;
  logic [7:0] wdata;
  modport source (output valid, func, reg_sel, wdata, input ready);
  modport sink   (input valid, func, reg_sel, wdata, output ready);
endinterface

interface dee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       write_busy;
  logic       done_flag;
  modport source (output valid, rdata, write_busy, done_flag, input ready);
  modport sink   (input valid, rdata, write_busy, done_flag, output ready);
endinterface

/* hdl/dee_mem.sv */
// EEPROM byte array with per-byte written bits; unwritten bytes read erased.
// Depends on dee_pkg.
module dee_mem import dee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]           mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [7:0]           q_r;
  logic                 q_vld_r;

  always_ff @(posedge clk) begin
    if (req_i.wr) begin
      mem_r[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      q_r <= mem_r[req_i.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (req_i.wr) begin
        vld_r[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        q_vld_r <= vld_r[req_i.addr];
      end
    end
  end

  assign rdata_o = q_vld_r ? q_r : ERASED_BYTE;

endmodule

/* hdl/dee_regs.sv */
// Register file, unlock sequencer and write timer of the EEPROM controller.
// Depends on dee_pkg; drives dee_mem through a mem_req_t.
module dee_regs import dee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go_i,
  input  logic [1:0]  func_i,
  input  logic [2:0]  sel_i,
  input  logic [7:0]  wdata_i,
  input  logic [15:0] write_ticks_i,
  input  logic [7:0]  mem_rdata_i,
  output mem_req_t    mem_req_o,
  output result_t     res_o
);

  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        use_mem_r, use_mem_nxt;
  logic [1:0]  space_r, space_nxt;
  logic        wren_r, wren_nxt;
  logic        active_r, active_nxt;
  logic [1:0]  lock_r, lock_nxt;
  logic        done_r, done_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] tick_inc;
  logic [7:0]  data_eff;
  logic [7:0]  rd;
  mem_req_t    req;

  // data register lives in the array read register after a read request
  assign data_eff = use_mem_r ? mem_rdata_i : data_r;
  assign tick_inc = tick_r + 16'd1;

  always_comb begin
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    use_mem_nxt = use_mem_r;
    space_nxt   = space_r;
    wren_nxt    = wren_r;
    active_nxt  = active_r;
    lock_nxt    = lock_r;
    done_nxt    = done_r;
    tick_nxt    = tick_r;
    rd          = 8'd0;
    req         = '0;
    req.addr    = addr_r[MEM_AW-1:0];
    req.wdata   = data_eff;
    case (func_i)
      FUNC_RD: begin
        case (sel_i)
          SEL_ADDR:   rd = addr_r;
          SEL_DATA:   rd = data_eff;
          SEL_CTRL:   rd = {space_r, 3'b000, wren_r, active_r, 1'b0};
          SEL_UNLOCK: lock_nxt = LOCK_IDLE;
          SEL_DONE:   rd = {7'd0, done_r};
          default: ;
        endcase
      end
      FUNC_WR: begin
        case (sel_i)
          SEL_ADDR: begin
            if (!active_r) addr_nxt = wdata_i;
          end
          SEL_DATA: begin
            if (!active_r) begin
              data_nxt    = wdata_i;
              use_mem_nxt = 1'b0;
            end
          end
          SEL_CTRL: begin
            space_nxt = wdata_i[7:6];
            wren_nxt  = wdata_i[2];
            if (wdata_i[0] && wdata_i[7:6] == 2'd0 && !active_r) begin
              req.rd      = 1'b1;
              use_mem_nxt = 1'b1;
            end
            if (wdata_i[1]) begin
              if (wren_r && lock_r == LOCK_OPEN && wdata_i[7:6] == 2'd0 && !active_r) begin
                active_nxt = 1'b1;
                tick_nxt   = 16'd0;
              end
              lock_nxt = LOCK_IDLE;
            end
          end
          SEL_UNLOCK: begin
            if (wdata_i == UNLOCK_FIRST) begin
              lock_nxt = LOCK_HALF;
            end else if (wdata_i == UNLOCK_SECOND && lock_r == LOCK_HALF) begin
              lock_nxt = LOCK_OPEN;
            end else begin
              lock_nxt = LOCK_IDLE;
            end
          end
          SEL_DONE: begin
            if (!wdata_i[0]) done_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (active_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= write_ticks_i) begin
            req.wr     = 1'b1;
            active_nxt = 1'b0;
            done_nxt   = 1'b1;
            tick_nxt   = 16'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_req_o    = req;
    mem_req_o.rd = req.rd & go_i;
    mem_req_o.wr = req.wr & go_i;
  end

  assign res_o = '{rdata: rd, write_busy: active_nxt, done_flag: done_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= 8'd0;
      data_r    <= 8'd0;
      use_mem_r <= 1'b0;
      space_r   <= 2'd0;
      wren_r    <= 1'b0;
      active_r  <= 1'b0;
      lock_r    <= LOCK_IDLE;
      done_r    <= 1'b0;
      tick_r    <= 16'd0;
    end else if (go_i) begin
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      use_mem_r <= use_mem_nxt;
      space_r   <= space_nxt;
      wren_r    <= wren_nxt;
      active_r  <= active_nxt;
      lock_r    <= lock_nxt;
      done_r    <= done_nxt;
      tick_r    <= tick_nxt;
    end
  end

endmodule

/* hdl/data_eeprom_controller_core.sv */
// Channel  | Dir | Payload                          | Handshake
// in_ch    | in  | func, reg_sel, wdata             | valid/ready
// out_ch   | out | rdata, write_busy, done_flag     | valid/ready
// cfg      | in  | cfg_wdata (write tick count)     | cfg_we, no wait
// One beat per cycle sustained while out_ch is ready: input register, one
// pass through the register logic and array port, result register.
// Synchronous active-low reset; the array reads erased until written.
// A stalled result holds; the input register keeps taking beats when
// the result register drains in the same cycle.
// Depends on dee_pkg, dee_if, dee_regs, dee_mem.
module data_eeprom_controller_core import dee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dee_in_if.sink      in_ch,
  dee_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        s1_vld_r;
  logic [1:0]  s1_func_r;
  logic [2:0]  s1_sel_r;
  logic [7:0]  s1_wdata_r;
  logic        out_vld_r;
  result_t     out_r;
  result_t     res;
  logic [15:0] write_ticks_r;
  logic        go;
  logic        in_beat;
  mem_req_t    mem_req;
  logic [7:0]  mem_rdata;

  assign go          = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || go;
  assign in_beat     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_ticks_r <= WRITE_TICKS_RST;
    end else if (cfg_we) begin
      write_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_vld_r <= 1'b1;
      end else if (go) begin
        s1_vld_r <= 1'b0;
      end
      if (go) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_func_r  <= in_ch.func;
      s1_sel_r   <= in_ch.reg_sel;
      s1_wdata_r <= in_ch.wdata;
    end
    if (go) begin
      out_r <= res;
    end
  end

  dee_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .go_i          (go),
    .func_i        (s1_func_r),
    .sel_i         (s1_sel_r),
    .wdata_i       (s1_wdata_r),
    .write_ticks_i (write_ticks_r),
    .mem_rdata_i   (mem_rdata),
    .mem_req_o     (mem_req),
    .res_o         (res)
  );

  dee_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign out_ch.valid      = out_vld_r;
  assign out_ch.rdata      = out_r.rdata;
  assign out_ch.write_busy = out_r.write_busy;
  assign out_ch.done_flag  = out_r.done_flag;

endmodule

/* hdl/dee_checker.sv */
// Port-level checks on the EEPROM controller result channel, bound to the top.
// Depends on data_eeprom_controller_core_macros.svh.
`include "data_eeprom_controller_core_macros.svh"

module dee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_rdata,
  input logic       out_write_busy,
  input logic       out_done_flag
);

  logic last_busy_r;
  logic last_done_r;
  logic out_beat;
  logic stall_beat;
  logic done_rise;
  logic busy_rise;
  logic write_end;

  assign out_beat   = out_valid && out_ready;
  assign stall_beat = out_valid && !out_ready;
  assign done_rise  = out_beat && out_done_flag && !last_done_r;
  assign busy_rise  = out_beat && out_write_busy && !last_busy_r;
  assign write_end  = last_busy_r && !out_write_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_busy_r <= 1'b0;
      last_done_r <= 1'b0;
    end else if (out_beat) begin
      last_busy_r <= out_write_busy;
      last_done_r <= out_done_flag;
    end
  end

  `DEE_ASSERT_ALL(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")
  `DEE_ASSERT_RUN(a_hold, stall_beat |=> out_valid && $stable(out_rdata), "stalled beat changed")
  `DEE_ASSERT_RUN(a_done_src, done_rise |-> write_end, "done set without finishing write")
  `DEE_ASSERT_RUN(a_start_rd, busy_rise |-> out_rdata == 8'h00, "write start returned data")

endmodule

bind data_eeprom_controller_core dee_checker u_dee_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_rdata      (out_ch.rdata),
  .out_write_busy (out_ch.write_busy),
  .out_done_flag  (out_ch.done_flag)
);

/* tb/testbench.sv */
// Self-checking bench for data_eeprom_controller_core: random register traffic and
// unlock/write sequences, scoreboarded against an in-bench model of the controller.
// Depends on dee_pkg, dee_if and the controller RTL.
`timescale 1ns / 100ps

module testbench;
  import dee_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CTRL_RD_BIT = 0;
  localparam int CTRL_WR_BIT = 1;
  localparam int CTRL_WREN_BIT = 2;
  localparam logic [7:0] CTRL_FREE_BITS = 8'h38;
  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic [1:0] func;
    logic [2:0] sel;
    logic [7:0] wdata;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  dee_in_if in_ch();
  dee_out_if out_ch();

  data_eeprom_controller_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  beat_t pending_beats[$];
  result_t expected_results[$];
  int queued_items = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // controller state as the bench sees it
  logic [7:0] m_mem[MEM_DEPTH];
  logic [7:0] m_addr, m_data;
  logic [1:0] m_space, m_lock;
  logic m_wren, m_active, m_done;
  logic [15:0] m_ticks, m_write_ticks;

  task automatic reset_model();
    foreach (m_mem[i]) m_mem[i] = ERASED_BYTE;
    m_addr = '0;
    m_data = '0;
    m_space = '0;
    m_lock = LOCK_IDLE;
    m_wren = 1'b0;
    m_active = 1'b0;
    m_done = 1'b0;
    m_ticks = '0;
    m_write_ticks = WRITE_TICKS_RST;
  endtask

  task automatic predict_access(input beat_t b);
    logic [7:0] rd;
    logic was_en;
    result_t r;
    rd = '0;
    case (b.func)
      FUNC_RD: begin
        case (b.sel)
          SEL_ADDR: rd = m_addr;
          SEL_DATA: rd = m_data;
          SEL_CTRL: rd = {m_space, 3'b000, m_wren, m_active, 1'b0};
          SEL_UNLOCK: m_lock = LOCK_IDLE;
          SEL_DONE: rd = {7'd0, m_done};
          default: ;
        endcase
      end
      FUNC_WR: begin
        case (b.sel)
          SEL_ADDR: if (!m_active) m_addr = b.wdata;
          SEL_DATA: if (!m_active) m_data = b.wdata;
          SEL_CTRL: begin
            was_en = m_wren;
            m_space = b.wdata[7:6];
            m_wren = b.wdata[CTRL_WREN_BIT];
            if (b.wdata[CTRL_RD_BIT] && m_space == 2'd0 && !m_active)
              m_data = m_mem[m_addr[MEM_AW-1:0]];
            if (b.wdata[CTRL_WR_BIT]) begin
              if (was_en && m_lock == LOCK_OPEN && m_space == 2'd0 && !m_active) begin
                m_active = 1'b1;
                m_ticks = '0;
              end
              m_lock = LOCK_IDLE;
            end
          end
          SEL_UNLOCK: begin
            if (b.wdata == UNLOCK_FIRST) m_lock = LOCK_HALF;
            else if (b.wdata == UNLOCK_SECOND && m_lock == LOCK_HALF) m_lock = LOCK_OPEN;
            else m_lock = LOCK_IDLE;
          end
          SEL_DONE: if (!b.wdata[0]) m_done = 1'b0;
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (m_active) begin
          m_ticks = m_ticks + 16'd1;
          if (m_ticks >= m_write_ticks) begin
            m_mem[m_addr[MEM_AW-1:0]] = m_data;
            m_active = 1'b0;
            m_done = 1'b1;
            m_ticks = '0;
          end
        end
      end
      default: ;
    endcase
    r.rdata = rd;
    r.write_busy = m_active;
    r.done_flag = m_done;
    expected_results.push_back(r);
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %02h expected %02h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: bursts of random length separated by random gaps
  beat_t cur_beat;
  int burst_left, gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_access(cur_beat);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the beat until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= cur_beat.func;
        in_ch.reg_sel <= cur_beat.sel;
        in_ch.wdata <= cur_beat.wdata;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 150);
            gap_left = $urandom_range(0, 1);
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(1, 6);
          end
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: ready follows a rotating mask that is redrawn now and then
  logic [7:0] stall_mask = 8'hFF;
  int mon_cycle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("result with nothing expected", out_ch.rdata, 8'h00);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          if (out_ch.rdata !== want.rdata) report("rdata", out_ch.rdata, want.rdata);
          if (out_ch.write_busy !== want.write_busy)
            report("write_busy", {7'd0, out_ch.write_busy}, {7'd0, want.write_busy});
          if (out_ch.done_flag !== want.done_flag)
            report("done_flag", {7'd0, out_ch.done_flag}, {7'd0, want.done_flag});
        end
      end
      mon_cycle++;
      if (mon_cycle % 97 == 0)
        stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      out_ch.ready <= stall_mask[mon_cycle % 8];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic put(input logic [1:0] f, input logic [2:0] s, input logic [7:0] d);
    beat_t b;
    b.func = f;
    b.sel = s;
    b.wdata = d;
    pending_beats.push_back(b);
    queued_items++;
  endtask

  task automatic put_noise();
    put(2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // address/data setup, unlock, start, ticks, then flag handling and read-back
  task automatic put_write_seq(input int tick_cap);
    int flaw, n;
    logic [7:0] ctl, bad;
    flaw = $urandom_range(0, 11);
    if ($urandom_range(0, 1)) put(FUNC_WR, SEL_ADDR, 8'($urandom));
    put(FUNC_WR, SEL_DATA, 8'($urandom));
    ctl = 8'($urandom) & CTRL_FREE_BITS;
    ctl[CTRL_WREN_BIT] = (flaw != 2);
    put(FUNC_WR, SEL_CTRL, ctl);
    if (flaw == 0) begin
      do bad = 8'($urandom); while (bad == UNLOCK_FIRST);
      put(FUNC_WR, SEL_UNLOCK, bad);
    end else if (flaw != 4) begin
      put(FUNC_WR, SEL_UNLOCK, UNLOCK_FIRST);
    end
    if (flaw == 1) put(FUNC_RD, SEL_UNLOCK, 8'($urandom));
    put(FUNC_WR, SEL_UNLOCK, UNLOCK_SECOND);
    ctl = 8'($urandom) & CTRL_FREE_BITS;
    ctl[CTRL_WREN_BIT] = 1'b1;
    ctl[CTRL_WR_BIT] = 1'b1;
    ctl[CTRL_RD_BIT] = ($urandom_range(0, 3) == 0);
    if (flaw == 3) ctl[7:6] = 2'($urandom_range(1, 3));
    put(FUNC_WR, SEL_CTRL, ctl);
    n = int'(m_write_ticks) + $urandom_range(0, 2);
    if (n > tick_cap) n = tick_cap;
    if (n < 1) n = 1;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        put($urandom_range(0, 1) ? FUNC_RD : FUNC_WR, 3'($urandom_range(0, 4)),
            8'($urandom));
      put(FUNC_TICK, 3'($urandom), 8'($urandom));
    end
    put(FUNC_RD, SEL_DONE, 8'($urandom));
    put(FUNC_WR, SEL_DONE, 8'($urandom) & (($urandom_range(0, 3) == 0) ? 8'hFF : 8'hFE));
    ctl = 8'($urandom) & (CTRL_FREE_BITS | 8'h04);
    ctl[CTRL_RD_BIT] = 1'b1;
    put(FUNC_WR, SEL_CTRL, ctl);
    put(FUNC_RD, SEL_DATA, 8'($urandom));
  endtask

  task automatic run_random(input int target, input int tick_cap);
    int start;
    start = queued_items;
    while (queued_items - start < target) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8)) put_noise();
      else put_write_seq(tick_cap);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_ch.valid === 1'b1 || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // drain, finish any running write, then let the pipeline empty
  task automatic settle();
    wait_idle();
    if (m_active) begin
      repeat ((m_write_ticks > m_ticks) ? int'(m_write_ticks - m_ticks) : 1)
        put(FUNC_TICK, SEL_ADDR, 8'h00);
      wait_idle();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_write_ticks(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    m_write_ticks = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  logic [15:0] tick_settings[5] = '{16'd1, 16'd0, 16'd5, 16'd17, 16'hFFFF};
  int phase_items[5] = '{400, 350, 400, 500, 200};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_RD;
    in_ch.reg_sel = SEL_ADDR;
    in_ch.wdata = 8'h00;
    out_ch.ready = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_write_ticks(16'd2);

    // reset values, erased read-back, one full write, done flag, space bits, unused codes
    put(FUNC_RD, SEL_ADDR, 8'hFF);
    put(FUNC_RD, SEL_DATA, 8'h00);
    put(FUNC_RD, SEL_CTRL, 8'hFF);
    put(FUNC_RD, SEL_UNLOCK, 8'h00);
    put(FUNC_RD, SEL_DONE, 8'hFF);
    put(FUNC_WR, SEL_ADDR, 8'hFF);
    put(FUNC_WR, SEL_DATA, 8'h5A);
    put(FUNC_WR, SEL_CTRL, 8'h01);
    put(FUNC_RD, SEL_DATA, 8'h00);
    put(FUNC_WR, SEL_DATA, 8'h00);
    put(FUNC_WR, SEL_CTRL, 8'h04);
    put(FUNC_WR, SEL_UNLOCK, UNLOCK_FIRST);
    put(FUNC_WR, SEL_UNLOCK, UNLOCK_SECOND);
    put(FUNC_WR, SEL_CTRL, 8'h06);
    put(FUNC_WR, SEL_ADDR, 8'h00);
    put(FUNC_WR, SEL_CTRL, 8'h07);
    put(FUNC_RD, SEL_CTRL, 8'h00);
    put(FUNC_TICK, SEL_ADDR, 8'h00);
    put(FUNC_TICK, 3'd7, 8'hFF);
    put(FUNC_RD, SEL_DONE, 8'h00);
    put(FUNC_WR, SEL_DONE, 8'h01);
    put(FUNC_WR, SEL_DONE, 8'hFE);
    put(FUNC_WR, SEL_CTRL, 8'h01);
    put(FUNC_RD, SEL_DATA, 8'h00);
    put(FUNC_WR, SEL_CTRL, 8'hC7);
    put(FUNC_RD, SEL_CTRL, 8'h00);
    put(FUNC_WR, 3'd5, 8'hFF);
    put(FUNC_RD, 3'd7, 8'hFF);
    put(FUNC_NONE, SEL_DONE, 8'hFF);

    foreach (tick_settings[i]) begin
      settle();
      set_write_ticks(tick_settings[i]);
      run_random(phase_items[i], 40);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/dee_pkg.sv
hdl/dee_if.sv
hdl/dee_mem.sv
hdl/dee_regs.sv
hdl/data_eeprom_controller_core.sv
hdl/dee_checker.sv
tb/testbench.sv
